>>> design/ket_pkg.sv
`default_nettype none
package ket_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int MOVE_BITS_DEF = 32;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int IDX_OUT_W     = 8;
    localparam int CNT_OUT_W     = 9;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_DELETE = 3'd2,
        OP_NEXT   = 3'd3,
        OP_PREV   = 3'd4,
        OP_RESET  = 3'd5,
        OP_READ   = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOCUR    = 2'd3;

    // key of one stored entry
    typedef struct packed {
        logic [WORD_W-1:0] bm;
        logic [WORD_W-1:0] bk;
        logic [WORD_W-1:0] wm;
        logic [WORD_W-1:0] wk;
    } key_t;

endpackage
`default_nettype wire

>>> design/ket_cell.sv
`default_nettype none
// One table slot; in a delete sweep it loads its right neighbor's entry.
module ket_cell
    import ket_pkg::*;
#(
    parameter int MOVE_BITS = MOVE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire key_t                 wr_key,
    input  wire logic [MOVE_BITS-1:0] wr_move,
    input  wire logic                 mv_en,
    input  wire logic                 shift_en,
    input  wire key_t                 nb_key,
    input  wire logic [MOVE_BITS-1:0] nb_move,
    output key_t                      key_q,
    output logic [MOVE_BITS-1:0]      move_q
);

    key_t                 key_reg;
    logic [MOVE_BITS-1:0] move_reg;

    // load new entry, overwrite move, or take neighbor
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg  <= nb_key;
            move_reg <= nb_move;
        end
        else if (wr_en)
        begin
            key_reg  <= wr_key;
            move_reg <= wr_move;
        end
        else if (mv_en)
        begin
            move_reg <= wr_move;
        end
    end

    assign key_q  = key_reg;
    assign move_q = move_reg;

endmodule
`default_nettype wire

>>> design/keyed_entry_table_with_cursor.sv
`default_nettype none
// Keyed entry table with cursor.
// Input channel (in_valid/in_ready) carries one item: an operation code, a
// four-word key and a move. Output channel (out_valid/out_ready) returns one
// result item per input item.
// Entries live in a row of cells. Insert and lookup walk the row one cell a
// cycle from entry zero; an insert into a full table ends with status full
// before any cell is written. Delete moves the cells above the cursor down
// one per cycle. One item is worked on at a time; the result waits in the
// output register while the receiver stalls, and the next item can be
// accepted in the cycle after the result leaves. Reset clears entry count and
// cursor; entry contents stay undefined and are never read beyond the count.
module keyed_entry_table_with_cursor
    import ket_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int MOVE_BITS = MOVE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [WORD_W-1:0]     key_black_men,
    input  wire logic [WORD_W-1:0]     key_black_kings,
    input  wire logic [WORD_W-1:0]     key_white_men,
    input  wire logic [WORD_W-1:0]     key_white_kings,
    input  wire logic [WORD_W-1:0]     move_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic                       hit,
    output logic [WORD_W-1:0]          move_out,
    output logic [WORD_W-1:0]          out_black_men,
    output logic [WORD_W-1:0]          out_black_kings,
    output logic [WORD_W-1:0]          out_white_men,
    output logic [WORD_W-1:0]          out_white_kings,
    output logic [IDX_OUT_W-1:0]       entry_index,
    output logic [CNT_OUT_W-1:0]       count_now,
    output logic [IDX_OUT_W-1:0]       cursor_now
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg;
    key_t                 key_reg;
    logic [MOVE_BITS-1:0] move_reg;
    logic [CW-1:0]        count_reg;
    logic [IW-1:0]        cursor_reg;
    logic [CW-1:0]        pos_reg;
    logic [IW-1:0]        rd_idx_reg;
    key_t                 rd_key_reg;
    logic [MOVE_BITS-1:0] rd_move_reg;

    logic [STATUS_W-1:0]  r_status_reg;
    logic                 r_hit_reg;
    logic [WORD_W-1:0]    r_move_reg;
    key_t                 r_key_reg;
    logic [IDX_OUT_W-1:0] r_idx_reg;

    key_t                 cell_key  [CAPACITY];
    logic [MOVE_BITS-1:0] cell_move [CAPACITY];
    logic [CAPACITY-1:0]  wr_en, mv_en, sh_en;

    key_t                 in_key;
    logic [MOVE_BITS-1:0] in_move;
    logic                 cur_ok;
    logic [IW-1:0]        pos_idx;
    logic                 match;

    assign in_key  = '{bm: key_black_men, bk: key_black_kings,
                       wm: key_white_men, wk: key_white_kings};
    assign in_move = MOVE_BITS'(move_in);
    assign cur_ok  = (count_reg != '0) && ({1'b0, cursor_reg} < count_reg);
    assign pos_idx = pos_reg[IW-1:0];
    assign match   = (rd_key_reg == key_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        key_t                 nb_k;
        logic [MOVE_BITS-1:0] nb_m;
        if (g == CAPACITY - 1)
        begin : g_last
            assign nb_k = cell_key[g];
            assign nb_m = cell_move[g];
        end
        else
        begin : g_mid
            assign nb_k = cell_key[g+1];
            assign nb_m = cell_move[g+1];
        end
        ket_cell #(.MOVE_BITS(MOVE_BITS)) u_cell (
            .clk(clk), .wr_en(wr_en[g]), .wr_key(key_reg), .wr_move(move_reg),
            .mv_en(mv_en[g]), .shift_en(sh_en[g]), .nb_key(nb_k),
            .nb_move(nb_m), .key_q(cell_key[g]), .move_q(cell_move[g])
        );
    end

    // decode cell strobes; an insert never writes a full table
    always_comb
    begin
        wr_en = '0;
        mv_en = '0;
        sh_en = '0;
        if (state_reg == S_SCAN && op_reg == OP_INSERT && count_reg != CW'(CAPACITY))
        begin
            if (pos_reg == count_reg)
                wr_en[count_reg[IW-1:0]] = 1'b1;
            else if (match)
                mv_en[rd_idx_reg] = 1'b1;
        end
        if (state_reg == S_SHIFT && (pos_reg + 1'b1) < count_reg)
            sh_en[pos_idx] = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SCAN;
            S_SCAN:
            begin
                case (op_reg)
                    OP_INSERT:
                        if (count_reg == CW'(CAPACITY) || pos_reg == count_reg || match)
                            state_next = S_OUT;
                    OP_LOOKUP:
                        if (pos_reg == count_reg || match)
                            state_next = S_OUT;
                    OP_DELETE:
                        state_next = cur_ok ? S_SHIFT : S_OUT;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_SHIFT:
                if ((pos_reg + 1'b1) >= count_reg)
                    state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCAN)
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg != CW'(CAPACITY) && pos_reg == count_reg)
                            count_reg <= count_reg + 1'b1;
                    end
                    OP_NEXT:
                    begin
                        if (count_reg != '0)
                            cursor_reg <= (({1'b0, cursor_reg} + 1'b1) >= count_reg)
                                ? '0 : cursor_reg + 1'b1;
                    end
                    OP_PREV:
                    begin
                        if (count_reg != '0)
                        begin
                            if (cursor_reg == '0)
                                cursor_reg <= IW'(count_reg - 1'b1);
                            else if ({1'b0, cursor_reg} >= count_reg)
                                // cursor beyond count: subtract count once and step back, or zero if still beyond
                                cursor_reg <= IW'(({1'b0, cursor_reg} -
                                    count_reg) >= count_reg ? '0 :
                                    ({1'b0, cursor_reg} - count_reg == '0 ?
                                    count_reg - 1'b1 :
                                    {1'b0, cursor_reg} - count_reg - 1'b1));
                            else
                                cursor_reg <= cursor_reg - 1'b1;
                        end
                    end
                    OP_RESET:
                        cursor_reg <= '0;
                    default: ;
                endcase
            end
            else if (state_reg == S_SHIFT)
            begin
                if ((pos_reg + 1'b1) >= count_reg)
                begin
                    count_reg <= count_reg - 1'b1;
                    if (count_reg == CW'(1))
                        cursor_reg <= '0;
                    else if ({1'b0, cursor_reg} >= count_reg - 1'b1)
                        cursor_reg <= IW'(count_reg - 2'd2);
                end
            end
        end
    end

    // datapath: item capture, scan pointer, read port, result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg     <= op_t'(operation);
            key_reg    <= in_key;
            move_reg   <= in_move;
            pos_reg    <= '0;
            rd_idx_reg <= '0;
            if (op_t'(operation) == OP_DELETE || op_t'(operation) == OP_READ)
            begin
                rd_key_reg  <= cell_key[cursor_reg];
                rd_move_reg <= cell_move[cursor_reg];
            end
            else
            begin
                rd_key_reg  <= cell_key[0];
                rd_move_reg <= cell_move[0];
            end
            r_status_reg <= ST_OK;
            r_hit_reg    <= 1'b0;
            r_move_reg   <= '0;
            r_key_reg    <= '0;
            r_idx_reg    <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            // delete starts its sweep at the cursor
            pos_reg     <= (op_reg == OP_DELETE) ? CW'(cursor_reg) : pos_reg + 1'b1;
            rd_idx_reg  <= IW'(pos_reg + 1'b1);
            rd_key_reg  <= cell_key[IW'(pos_reg + 1'b1)];
            rd_move_reg <= cell_move[IW'(pos_reg + 1'b1)];
            case (op_reg)
                OP_INSERT:
                    if (count_reg == CW'(CAPACITY))
                        r_status_reg <= ST_FULL;
                    else if (pos_reg == count_reg || match)
                    begin
                        r_hit_reg  <= (pos_reg != count_reg);
                        r_move_reg <= WORD_W'(move_reg);
                        r_idx_reg  <= IDX_OUT_W'(pos_reg);
                    end
                OP_LOOKUP:
                    if (pos_reg == count_reg)
                        r_status_reg <= ST_NOTFOUND;
                    else if (match)
                    begin
                        r_hit_reg  <= 1'b1;
                        r_move_reg <= WORD_W'(rd_move_reg);
                        r_idx_reg  <= IDX_OUT_W'(pos_reg);
                    end
                OP_DELETE:
                begin
                    if (cur_ok)
                        r_idx_reg <= IDX_OUT_W'(cursor_reg);
                    else
                        r_status_reg <= ST_NOCUR;
                end
                OP_NEXT, OP_PREV:
                    if (count_reg == '0)
                        r_status_reg <= ST_NOCUR;
                OP_READ:
                    if (cur_ok)
                    begin
                        r_idx_reg  <= IDX_OUT_W'(cursor_reg);
                        r_move_reg <= WORD_W'(rd_move_reg);
                        r_key_reg  <= rd_key_reg;
                    end
                    else
                        r_status_reg <= ST_NOCUR;
                default: ;
            endcase
        end
        else if (state_reg == S_SHIFT)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // cursor-step ops report the new cursor
    always_comb
    begin
        entry_index = r_idx_reg;
        if ((op_reg == OP_NEXT || op_reg == OP_PREV) && r_status_reg == ST_OK)
            entry_index = IDX_OUT_W'(cursor_reg);
    end

    assign status          = r_status_reg;
    assign hit             = r_hit_reg;
    assign move_out        = r_move_reg;
    assign out_black_men   = r_key_reg.bm;
    assign out_black_kings = r_key_reg.bk;
    assign out_white_men   = r_key_reg.wm;
    assign out_white_kings = r_key_reg.wk;
    assign count_now       = CNT_OUT_W'(count_reg);
    assign cursor_now      = IDX_OUT_W'(cursor_reg);

    // checks
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)) else $error("count over capacity");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count_reg))
        else $error("result dropped");
    a_shift_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sh_en)) else $error("multiple shift strobes");
    a_cursor_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_reg != '0 && (op_reg == OP_NEXT || op_reg == OP_DELETE)
        |-> {1'b0, cursor_reg} < count_reg) else $error("cursor outside table");

endmodule
`default_nettype wire

>>> verif/tb_keyed_entry_table_with_cursor.sv
`default_nettype none
module tb_keyed_entry_table_with_cursor;
    import ket_pkg::*;

    localparam int CAP = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 hit;
        logic [31:0]          move;
        logic [31:0]          bm;
        logic [31:0]          bk;
        logic [31:0]          wm;
        logic [31:0]          wk;
        logic [7:0]           index;
        logic [8:0]           count;
        logic [7:0]           cursor;
    } table_reply_t;

    // Shadow copy of the table; predicts one reply per item
    class table_scoreboard;
        key_t          keys [CAP];
        logic [31:0]   moves [CAP];
        int            count;
        int            cursor;
        table_reply_t  pending [$];
        int            mismatches;
        int            checked;
        int            op_seen [8];

        function void note_item(op_t op, key_t k, logic [31:0] mv);
            table_reply_t r;
            int i;
            int found;
            bit cur_ok;
            r = '0;
            found = -1;
            cur_ok = count > 0 && cursor < count;
            op_seen[op]++;
            for (i = 0; i < count; i++)
            begin
                if (found < 0 && keys[i] == k)
                    found = i;
            end
            case (op)
                OP_INSERT:
                begin
                    if (count >= CAP)
                        r.status = ST_FULL;
                    else if (found >= 0)
                    begin
                        moves[found] = mv;
                        r.hit = 1'b1;
                        r.index = found[7:0];
                        r.move = mv;
                    end
                    else
                    begin
                        keys[count] = k;
                        moves[count] = mv;
                        r.index = count[7:0];
                        r.move = mv;
                        count++;
                    end
                end
                OP_LOOKUP:
                begin
                    if (found >= 0)
                    begin
                        r.hit = 1'b1;
                        r.index = found[7:0];
                        r.move = moves[found];
                    end
                    else
                        r.status = ST_NOTFOUND;
                end
                OP_DELETE:
                begin
                    if (!cur_ok)
                        r.status = ST_NOCUR;
                    else
                    begin
                        r.index = cursor[7:0];
                        for (i = cursor; i + 1 < count; i++)
                        begin
                            keys[i] = keys[i+1];
                            moves[i] = moves[i+1];
                        end
                        count--;
                        if (count == 0)
                            cursor = 0;
                        else if (cursor >= count)
                            cursor = count - 1;
                    end
                end
                OP_NEXT, OP_PREV:
                begin
                    if (count == 0)
                        r.status = ST_NOCUR;
                    else
                    begin
                        if (op == OP_NEXT)
                            cursor = (cursor + 1) % count;
                        else
                            cursor = (cursor % count + count - 1) % count;
                        r.index = cursor[7:0];
                    end
                end
                OP_RESET: cursor = 0;
                OP_READ:
                begin
                    if (!cur_ok)
                        r.status = ST_NOCUR;
                    else
                    begin
                        r.index = cursor[7:0];
                        r.move = moves[cursor];
                        r.bm = keys[cursor].bm;
                        r.bk = keys[cursor].bk;
                        r.wm = keys[cursor].wm;
                        r.wk = keys[cursor].wk;
                    end
                end
                default: ;
            endcase
            r.count = count[8:0];
            r.cursor = cursor[7:0];
            pending.push_back(r);
        endfunction

        function void check_reply(table_reply_t got);
            table_reply_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply %0d mismatch: expected %h got %h", checked, want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [OP_W-1:0] operation = '0;
    logic [31:0] key_black_men = '0, key_black_kings = '0;
    logic [31:0] key_white_men = '0, key_white_kings = '0;
    logic [31:0] move_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic hit;
    logic [31:0] move_out, out_black_men, out_black_kings, out_white_men, out_white_kings;
    logic [7:0] entry_index, cursor_now;
    logic [8:0] count_now;

    table_scoreboard sb = new();
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit no_stall = 1'b0;
    key_t key_pool [8];
    int max_count = 0;

    keyed_entry_table_with_cursor dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        if (no_stall)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // Check each reply; drop ready at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply({status, hit, move_out, out_black_men, out_black_kings,
                            out_white_men, out_white_kings, entry_index, count_now,
                            cursor_now});
        out_ready <= no_stall ? 1'b1 : ($urandom_range(0, 9) < 7);
    end

    // Watchdog on cycles with no accepted item and no taken reply
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // Valid drops only for a gap, so back-to-back items keep it high
    task automatic send_item(op_t op, key_t k, logic [31:0] mv);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        {key_black_men, key_black_kings, key_white_men, key_white_kings} <= k;
        move_in <= mv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(op, k, mv);
        if (sb.count > max_count)
            max_count = sb.count;
    endtask

    function automatic key_t rand_key();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // Mostly keys from a small pool so that hits and overwrites occur
    function automatic key_t pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 7)];
        return rand_key();
    endfunction

    task automatic random_items(int n, int insert_weight);
        int i;
        op_t op;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < insert_weight)
                op = OP_INSERT;
            else
                op = op_t'($urandom_range(1, 7));
            send_item(op, pick_key(), $urandom());
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < 8; i++)
            key_pool[i] = rand_key();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operations on an empty table, then extremes
        send_item(OP_DELETE, '0, '0);
        send_item(OP_NEXT, '0, '0);
        send_item(OP_PREV, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_NONE, '1, '1);
        send_item(OP_INSERT, '0, '1);
        send_item(OP_INSERT, '1, '0);
        send_item(OP_INSERT, '1, 32'h5a5a_a5a5);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_LOOKUP, '0, '0);
        send_item(OP_PREV, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_NEXT, '0, '0);
        send_item(OP_RESET, '0, '0);
        send_item(OP_NEXT, '0, '0);
        send_item(OP_DELETE, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_DELETE, '0, '0);
        send_item(OP_DELETE, '0, '0);

        // Random mix on a small table
        random_items(500, 30);

        // Fill to capacity, stress full-table refusal and deletes at the end
        while (sb.count < CAP)
            send_item(OP_INSERT, rand_key(), $urandom());
        send_item(OP_INSERT, key_pool[0], '1);
        send_item(OP_INSERT, rand_key(), '1);
        no_stall = 1'b1;
        send_item(OP_PREV, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_DELETE, '0, '0);
        send_item(OP_INSERT, '1, '1);
        no_stall = 1'b0;
        random_items(300, 20);

        // Delete-heavy mix with few inserts, then random again
        random_items(300, 5);
        random_items(300, 40);
        in_valid <= 1'b0;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("items per op code: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
                 sb.op_seen[4], sb.op_seen[5], sb.op_seen[6], sb.op_seen[7]);
        $display("replies checked %0d, peak table size %0d", sb.checked, max_count);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
design/ket_pkg.sv
design/ket_cell.sv
design/keyed_entry_table_with_cursor.sv
verif/tb_keyed_entry_table_with_cursor.sv
